>>> design/bpqe_pkg.sv
// Package for the bounded priority queue with tail eviction.
// Holds the command and status codes and the item and cell structs.
// No dependencies; every other file in the design imports it.
package bpqe_pkg;

	localparam int unsigned FillWidth = 4;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  prio;
		logic [15:0] payload;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic                 evicted;
		logic [7:0]           out_prio;
		logic [15:0]          out_payload;
		logic [FillWidth-1:0] fill;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic        en;
		logic        pop;
		logic [7:0]  prio;
		logic [15:0] tag;
	} cell_ctrl_t;

endpackage

>>> design/bpqe_req_if.sv
// Request channel of the priority queue: valid, ready and one request item.
// Depends on bpqe_pkg.
interface bpqe_req_if
	import bpqe_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/bpqe_rsp_if.sv
// Response channel of the priority queue: valid, ready and one result item.
// Depends on bpqe_pkg.
interface bpqe_rsp_if
	import bpqe_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/bpqe_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on bpqe_pkg.
module bpqe_cell
	import bpqe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       tie_ok,
	input  entry_t     left,
	input  logic       left_lower,
	input  entry_t     right,
	output entry_t     entry,
	output logic       lower
);

	logic        valid_q;
	logic [7:0]  prio_q;
	logic [15:0] tag_q;
	entry_t      entry_d;

	assign entry = '{valid: valid_q, prio: prio_q, tag: tag_q};

	// A slot yields to the arrival when it is empty or holds a strictly lower priority.
	// The tail slot also yields on equal priority, which makes room when full.
	always_comb begin
		lower = !valid_q || (prio_q < ctrl.prio) ||
			(tie_ok && (prio_q == ctrl.prio));
		entry_d = entry;
		if (ctrl.pop) begin
			entry_d = right;
		end else if (left_lower) begin
			entry_d = left;
		end else if (lower) begin
			entry_d = '{valid: 1'b1, prio: ctrl.prio, tag: ctrl.tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.en) begin
			valid_q <= entry_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prio_q <= entry_d.prio;
			tag_q  <= entry_d.tag;
		end
	end

endmodule

>>> design/bounded_priority_queue_evict.sv
// Bounded priority queue, highest priority first, arrival order kept among equal
// priorities. It takes one push or pop per cycle and answers each with one registered result
// in the next cycle; the chain of DEPTH slots compares and shifts in every slot at once, so
// the only stall comes from a result that is still waiting to be taken.
module bounded_priority_queue_evict
	import bpqe_pkg::*;
#(
	parameter int unsigned DEPTH = 8
) (
	input logic       clk,
	input logic       arst_n,
	bpqe_req_if.sink  req,
	bpqe_rsp_if.source rsp
);

	localparam int unsigned CntWidth = $clog2(DEPTH + 1);

	entry_t               entries [DEPTH];
	logic                 lowers  [DEPTH];
	cell_ctrl_t           ctrl;
	logic                 fire;
	logic                 full;
	logic                 empty;
	logic                 refused;
	logic [CntWidth-1:0]  cnt_q;
	logic [CntWidth-1:0]  cnt_d;
	logic [CntWidth+FillWidth-1:0] fill_ext;
	rsp_t                 rsp_d;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = entries[DEPTH-1].valid;
	assign empty     = !entries[0].valid;
	assign refused   = full && !lowers[DEPTH-1];

	assign ctrl.en   = fire;
	assign ctrl.pop  = (req.data.cmd == CMD_POP);
	assign ctrl.prio = req.data.prio;
	assign ctrl.tag  = req.data.payload;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_low;

		if (i == 0) begin : g_head
			assign left_e   = '0;
			assign left_low = 1'b0;
		end else begin : g_mid
			assign left_e   = entries[i-1];
			assign left_low = lowers[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = entries[i+1];
		end

		bpqe_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.tie_ok     (i == DEPTH - 1),
			.left       (left_e),
			.left_lower (left_low),
			.right      (right_e),
			.entry      (entries[i]),
			.lower      (lowers[i])
		);
	end

	always_comb begin
		cnt_d = cnt_q;
		rsp_d = '{status: ST_ACCEPTED, evicted: 1'b0, out_prio: '0,
			out_payload: '0, fill: '0};
		if (ctrl.pop) begin
			if (empty) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.status      = ST_POPPED;
				rsp_d.out_prio    = entries[0].prio;
				rsp_d.out_payload = entries[0].tag;
				cnt_d             = cnt_q - 1'b1;
			end
		end else if (refused) begin
			rsp_d.status = ST_FULL;
		end else if (full) begin
			rsp_d.evicted = 1'b1;
		end else begin
			cnt_d = cnt_q + 1'b1;
		end
		fill_ext   = {{FillWidth{1'b0}}, cnt_d};
		rsp_d.fill = fill_ext[FillWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q       <= cnt_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for bounded_priority_queue_evict: directed and random push/pop
// traffic with random idling on both channels, checked against an in-bench sorted queue.
// Depends on bpqe_pkg, bpqe_req_if, bpqe_rsp_if and the top-level RTL module.
module tb_top
	import bpqe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH = 8;
	localparam int unsigned RX_HOLD_CYCLES = 60;

	typedef struct {
		req_t        op;
		int unsigned gap;
		bit          drain;
		bit          stall_rx;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpqe_req_if req_ch ();
	bpqe_rsp_if rsp_ch ();

	bounded_priority_queue_evict #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	stim_t pending_ops[$];
	rsp_t due_results[$];

	logic [7:0] sorted_prio[QDEPTH];
	logic [15:0] sorted_tag[QDEPTH];
	int unsigned held = 0;

	int mismatches = 0;
	int unsigned n_accepted = 0;
	int unsigned n_evicted = 0;
	int unsigned n_refused = 0;
	int unsigned n_popped = 0;
	int unsigned n_empty = 0;
	int unsigned hold_reqs = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Applies one operation to the in-bench queue and returns the result it must produce.
	function automatic rsp_t queue_step(input req_t r);
		rsp_t res;
		int unsigned at;
		res = '0;
		res.status = ST_ACCEPTED;
		if (r.cmd == CMD_POP) begin
			if (held == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.status = ST_POPPED;
				res.out_prio = sorted_prio[0];
				res.out_payload = sorted_tag[0];
				for (int i = 1; i < held; i++) begin
					sorted_prio[i-1] = sorted_prio[i];
					sorted_tag[i-1] = sorted_tag[i];
				end
				held--;
			end
		end else if (held >= QDEPTH && sorted_prio[QDEPTH-1] > r.prio) begin
			res.status = ST_FULL;
		end else begin
			if (held >= QDEPTH) begin
				held = QDEPTH - 1;
				res.evicted = 1'b1;
			end
			at = held;
			for (int i = 0; i < held; i++) begin
				if (sorted_prio[i] < r.prio) begin
					at = i;
					break;
				end
			end
			for (int i = held; i > at; i--) begin
				sorted_prio[i] = sorted_prio[i-1];
				sorted_tag[i] = sorted_tag[i-1];
			end
			sorted_prio[at] = r.prio;
			sorted_tag[at] = r.payload;
			held++;
		end
		res.fill = FillWidth'(held);
		return res;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [7:0] pick_prio();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) return 8'($urandom_range(0, 255));
		if (roll < 8) return 8'($urandom_range(0, 3) * 85);
		if (roll == 8) return 8'd0;
		return 8'd255;
	endfunction

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_op(input cmd_t c, input logic [7:0] p, input logic [15:0] t,
			input int unsigned gap, input bit drain, input bit stall_rx);
		stim_t s;
		s.op.cmd = c;
		s.op.prio = p;
		s.op.payload = t;
		s.gap = gap;
		s.drain = drain;
		s.stall_rx = stall_rx;
		pending_ops.push_back(s);
	endtask

	initial begin : build_stimulus
		int unsigned push_pct;
		bit quiet;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;

		// Directed part: empty pop, ties, fill to capacity, eviction and refusal, drain.
		add_op(CMD_POP, 8'hFF, 16'hFFFF, 0, 0, 0);
		add_op(CMD_PUSH, 8'd10, 16'h0000, 0, 0, 0);
		add_op(CMD_PUSH, 8'd255, 16'hFFFF, 0, 0, 0);
		add_op(CMD_PUSH, 8'd0, 16'h1234, 0, 0, 0);
		add_op(CMD_PUSH, 8'd10, 16'hAAAA, 0, 0, 0);
		add_op(CMD_PUSH, 8'd128, 16'h5555, 0, 0, 0);
		add_op(CMD_PUSH, 8'd10, 16'h0F0F, 0, 0, 0);
		add_op(CMD_PUSH, 8'd255, 16'h8001, 0, 0, 0);
		add_op(CMD_PUSH, 8'd64, 16'h7FFE, 0, 0, 0);
		add_op(CMD_PUSH, 8'd0, 16'hC3C3, 0, 0, 0);
		add_op(CMD_PUSH, 8'd5, 16'h3C3C, 0, 0, 0);
		add_op(CMD_PUSH, 8'd3, 16'h9999, 0, 0, 0);
		add_op(CMD_PUSH, 8'd255, 16'h6666, 0, 0, 0);
		for (int i = 0; i < QDEPTH; i++) begin
			add_op(CMD_POP, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
				0, 0, 0);
		end
		add_op(CMD_POP, 8'h00, 16'h0000, 0, 0, 0);

		// Random part in blocks, each with its own push/pop mix and idling style.
		for (int blk = 0; blk < 13; blk++) begin
			case ($urandom_range(0, 2))
				0: push_pct = 30;
				1: push_pct = 55;
				default: push_pct = 85;
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 50; k++) begin
				add_op(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
					pick_prio(), 16'($urandom_range(0, 65535)),
					quiet ? 0 : idle_len(),
					(blk == 0 && k == 0) || (blk == 8 && k == 0),
					(blk == 4 && k == 0));
				if (blk == 4 && k == 0) begin
					pending_ops[$].op.cmd = CMD_PUSH;
					pending_ops[$].gap = 0;
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		stim_t nxt;
		bit offering;
		int unsigned gap_left;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			gap_left = 0;
		end else begin
			offering = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(queue_step(req_ch.data));
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_ops.size() > 0 &&
						!(pending_ops[0].drain && due_results.size() > 0)) begin
					nxt = pending_ops.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.data <= nxt.op;
					gap_left = nxt.gap;
					if (nxt.stall_rx) begin
						hold_reqs <= hold_reqs + 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive_ready
		int unsigned hold_seen;
		int unsigned hold_left;
		int unsigned phase_left;
		bit rdy_phase;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			phase_left = 0;
			rdy_phase = 1'b0;
		end else begin
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					rdy_phase = !rdy_phase;
					phase_left = rdy_phase ? $urandom_range(1, 40) : idle_len() + 1;
				end
				phase_left--;
				rsp_ch.ready <= rdy_phase;
			end
		end
	end

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time,
					rsp_ch.data);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("status", want.status, rsp_ch.data.status);
				check_field("evicted", want.evicted, rsp_ch.data.evicted);
				check_field("out_prio", want.out_prio, rsp_ch.data.out_prio);
				check_field("out_payload", want.out_payload, rsp_ch.data.out_payload);
				check_field("fill", want.fill, rsp_ch.data.fill);
			end
			case (rsp_ch.data.status)
				ST_ACCEPTED: begin
					n_accepted++;
					if (rsp_ch.data.evicted) n_evicted++;
				end
				ST_FULL: n_refused++;
				ST_POPPED: n_popped++;
				default: n_empty++;
			endcase
		end
	end

	initial begin : finish_run
		wait (arst_n);
		while (pending_ops.size() > 0 || req_ch.valid || due_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (5) @(posedge clk);
		$display("Checked %0d accepted pushes (%0d with tail eviction), %0d refused pushes,",
			n_accepted, n_evicted, n_refused);
		$display("%0d pops returning an entry and %0d pops on an empty queue.",
			n_popped, n_empty);
		if (mismatches == 0) begin
			$display("[bounded_priority_queue_evict] OK");
		end else begin
			$display("[bounded_priority_queue_evict] ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("[bounded_priority_queue_evict] ERROR");
		$finish;
	end

endmodule

>>> files.f
design/bpqe_pkg.sv
design/bpqe_req_if.sv
design/bpqe_rsp_if.sv
design/bpqe_cell.sv
design/bounded_priority_queue_evict.sv
dv/tb_top.sv
